>>> rtl/gbaim_pkg.sv
// Shared types and constants for the granule bank address/index map.
// Holds the channel payload structs, the bank map struct and register codes.
// No dependencies.
package gbaim_pkg;

    localparam int ADDR_W        = 48;
    localparam int IDX_W         = 36;
    localparam int GRANULE_SHIFT = 12;
    localparam int BANK_LIMIT    = 2;
    localparam int REG_BANKS     = 2;
    localparam int CNT_W         = ADDR_W - GRANULE_SHIFT + 1;
    localparam int TOT_W         = CNT_W + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int BCNT_W        = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BANK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANK0_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANK0_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BANK1_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BANK1_END   = 3'd4;

    // Commands
    localparam logic CMD_ADDR_TO_IDX = 1'b0;
    localparam logic CMD_IDX_TO_ADDR = 1'b1;

    localparam logic [BCNT_W-1:0] BANK_CAP =
        (BANK_LIMIT < REG_BANKS) ? BCNT_W'(BANK_LIMIT) : BCNT_W'(REG_BANKS);

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  granule_index;
    } gbaim_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_value;
        logic              valid_res;
    } gbaim_out_t;

    // Bank map as seen by the translation logic; counts are zero for unused banks
    typedef struct packed {
        logic [BCNT_W-1:0] banks;
        logic [ADDR_W-1:0] start0;
        logic [ADDR_W-1:0] end0;
        logic [ADDR_W-1:0] start1;
        logic [ADDR_W-1:0] end1;
        logic [CNT_W-1:0]  cnt0;
        logic [CNT_W-1:0]  cnt1;
        logic [TOT_W-1:0]  total;
    } gbaim_map_t;

endpackage

>>> rtl/gbaim_cfg_regs.sv
// Configuration registers and derived bank granule counts.
// Depends on gbaim_pkg.
module gbaim_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gbaim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbaim_pkg::ADDR_W-1:0]      cfg_data,
    output gbaim_pkg::gbaim_map_t             map
);
    import gbaim_pkg::*;

    logic [BCNT_W-1:0] bank_count_reg;
    logic [ADDR_W-1:0] start0_reg, end0_reg, start1_reg, end1_reg;
    gbaim_map_t        map_reg, map_next;

    logic [BCNT_W-1:0] banks;
    logic [ADDR_W:0]   span0, span1;
    logic [CNT_W-1:0]  cnt0, cnt1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_count_reg <= '0;
            start0_reg     <= '0;
            end0_reg       <= '0;
            start1_reg     <= '0;
            end1_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_BANK_COUNT:  bank_count_reg <= cfg_data[BCNT_W-1:0];
                REG_BANK0_START: start0_reg     <= cfg_data;
                REG_BANK0_END:   end0_reg       <= cfg_data;
                REG_BANK1_START: start1_reg     <= cfg_data;
                REG_BANK1_END:   end1_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        banks = (bank_count_reg > BANK_CAP) ? BANK_CAP : bank_count_reg;
        span0 = {1'b0, end0_reg} - {1'b0, start0_reg} + (ADDR_W+1)'(1);
        span1 = {1'b0, end1_reg} - {1'b0, start1_reg} + (ADDR_W+1)'(1);
        // reversed or unused banks hold no granules
        cnt0  = (end0_reg >= start0_reg && banks >= 2'd1) ?
                span0[ADDR_W:GRANULE_SHIFT] : '0;
        cnt1  = (end1_reg >= start1_reg && banks >= 2'd2) ?
                span1[ADDR_W:GRANULE_SHIFT] : '0;
        map_next        = '0;
        map_next.banks  = banks;
        map_next.start0 = start0_reg;
        map_next.end0   = end0_reg;
        map_next.start1 = start1_reg;
        map_next.end1   = end1_reg;
        map_next.cnt0   = cnt0;
        map_next.cnt1   = cnt1;
        map_next.total  = TOT_W'(cnt0) + TOT_W'(cnt1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= '0;
        end else begin
            map_reg <= map_next;
        end
    end

    assign map = map_reg;

    a_banks_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        map_reg.banks <= BANK_CAP)
        else $error("bank count in use exceeds cap");
    a_unused_bank_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (map_reg.banks < 2'd2) |-> (map_reg.cnt1 == '0))
        else $error("unused bank carries granules");
    a_empty_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (map_reg.banks == 2'd0) |-> (map_reg.total == '0))
        else $error("empty map has nonzero total");

endmodule

>>> rtl/gbaim_xlate.sv
// Combinational address/index translation over the registered bank map.
// Depends on gbaim_pkg.
module gbaim_xlate (
    input  gbaim_pkg::gbaim_in_t   item,
    input  gbaim_pkg::gbaim_map_t  map,
    output gbaim_pkg::gbaim_out_t  res
);
    import gbaim_pkg::*;

    logic              aligned, in0, in1, hit0, in_range;
    logic [ADDR_W-1:0] diff0, diff1;
    logic [ADDR_W-1:0] idx_res, addr_res;
    logic [TOT_W-1:0]  idx_off;
    logic              ok;

    always_comb begin
        aligned = (item.address[GRANULE_SHIFT-1:0] == '0);
        in0 = (map.banks >= 2'd1) && (item.address >= map.start0)
              && (item.address <= map.end0);
        in1 = (map.banks >= 2'd2) && (item.address >= map.start1)
              && (item.address <= map.end1);
        diff0 = item.address - map.start0;
        diff1 = item.address - map.start1;
        // first matching bank wins
        if (in0) begin
            idx_res = ADDR_W'(diff0[ADDR_W-1:GRANULE_SHIFT]);
        end else begin
            idx_res = ADDR_W'(map.cnt0) + ADDR_W'(diff1[ADDR_W-1:GRANULE_SHIFT]);
        end

        in_range = TOT_W'(item.granule_index) < map.total;
        hit0     = CNT_W'(item.granule_index) < map.cnt0;
        idx_off  = TOT_W'(item.granule_index) - TOT_W'(map.cnt0);
        if (hit0) begin
            addr_res = map.start0 + (ADDR_W'(item.granule_index) << GRANULE_SHIFT);
        end else begin
            addr_res = map.start1 + (ADDR_W'(idx_off) << GRANULE_SHIFT);
        end

        case (item.command)
            CMD_ADDR_TO_IDX: ok = (map.total != '0) && aligned && (in0 || in1);
            CMD_IDX_TO_ADDR: ok = in_range;
            default:         ok = 1'b0;
        endcase

        res.valid_res    = ok;
        res.result_value = !ok ? '0 :
                           (item.command == CMD_IDX_TO_ADDR) ? addr_res : idx_res;
    end

endmodule

>>> rtl/granule_bank_address_index_map.sv
// Granule bank address/index map. Each transfer is one command: address to
// granule index, or granule index to granule base address, over up to two
// banks. An item passes an input register, the translation logic and an
// output register: one item per cycle sustained while m_ready holds, set
// by the single register stage on each side of the translation. Bank counts
// are derived from the configuration registers and held in a registered map;
// results never stall the input while the output register can drain.
// Depends on gbaim_pkg, gbaim_cfg_regs and gbaim_xlate.
module granule_bank_address_index_map (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  gbaim_pkg::gbaim_in_t             s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output gbaim_pkg::gbaim_out_t            m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gbaim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gbaim_pkg::ADDR_W-1:0]     cfg_data
);
    import gbaim_pkg::*;

    gbaim_map_t  map;
    gbaim_in_t   in_data_reg;
    logic        in_vld_reg;
    gbaim_out_t  out_data_reg, xlate_res;
    logic        out_vld_reg;
    logic        out_free, in_free;

    gbaim_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .map       (map)
    );

    gbaim_xlate u_xlate (
        .item (in_data_reg),
        .map  (map),
        .res  (xlate_res)
    );

    assign out_free = !out_vld_reg || m_ready;
    assign in_free  = !in_vld_reg || out_free;
    assign s_ready  = in_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_free) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_free && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // advance the translated item only when the output slot drains
    always_ff @(posedge aclk) begin
        if (out_free && in_vld_reg) begin
            out_data_reg <= xlate_res;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> (m_data.result_value == '0))
        else $error("invalid result carries nonzero value");
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_ready)
        else $error("empty input stage refuses a transfer");
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_free) |=> out_vld_reg)
        else $error("item in input stage was lost");

endmodule
